@@ design/crfp_pkg.sv @@
// ----------------------------------------------------------------------------
// crfp_pkg
// Shared types and constants for the card reader reply frame parser.
// ----------------------------------------------------------------------------
package crfp_pkg;

    localparam int MAX_FRAME_DEF = 64;
    localparam logic [7:0] MIN_FRAME = 8'd3;

    // positions of the captured fields within a frame
    localparam logic [7:0] POS_LENGTH     = 8'd1;
    localparam logic [7:0] POS_COMMAND    = 8'd2;
    localparam logic [7:0] POS_STATUS     = 8'd4;
    localparam logic [7:0] POS_TYPE_FIRST = 8'd5;
    localparam logic [7:0] POS_TYPE_LAST  = 8'd6;
    localparam logic [7:0] POS_NUM_FIRST  = 8'd7;
    localparam logic [7:0] POS_NUM_LAST   = 8'd10;

    // shortest frames that carry a status byte and full card data
    localparam logic [7:0] LEN_WITH_STATUS = 8'd5;
    localparam logic [7:0] LEN_WITH_CARD   = 8'd12;

    localparam logic [7:0] CMD_READ_CARD   = 8'hA1;
    localparam logic [7:0] CMD_READ_BLOCK  = 8'hA3;
    localparam logic [7:0] CMD_WRITE_BLOCK = 8'hA4;
    localparam logic [7:0] STATUS_OK       = 8'h00;

    typedef enum logic [2:0] {
        RES_CARD_OK     = 3'd0,
        RES_CARD_FAIL   = 3'd1,
        RES_CARD_SHORT  = 3'd2,
        RES_READ_BLOCK  = 3'd3,
        RES_WRITE_BLOCK = 3'd4,
        RES_OTHER       = 3'd5,
        RES_BAD_LENGTH  = 3'd6
    } result_code_t;

    typedef struct packed {
        result_code_t code;
        logic [7:0]   command;
        logic [7:0]   status;
        logic [15:0]  card_type;
        logic [31:0]  card_number;
        logic         sum_ok;
        logic [7:0]   length;
    } result_t;

endpackage

@@ design/card_reader_frame_parser_top.sv @@
// ----------------------------------------------------------------------------
// card_reader_frame_parser_top
// Parses card reader reply frames byte by byte and reports one result per frame.
// ----------------------------------------------------------------------------
// the byte that ends a frame is held in the input register, and its result is loaded
// into the output register as that byte moves on into the parser
// throughput: one byte per cycle, set by the single-pass parse stage
// a stalled output holds back only bytes that end a frame
// reset clears the input and output valid flags and all frame state
module card_reader_frame_parser_top #(
    parameter int MAX_FRAME = crfp_pkg::MAX_FRAME_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [7:0]            rx_byte,
    output logic                  out_valid,
    input  logic                  out_stall,
    output crfp_pkg::result_code_t result_code,
    output logic [7:0]            command_code,
    output logic [7:0]            reply_status,
    output logic [15:0]           card_type,
    output logic [31:0]           card_number,
    output logic                  checksum_ok,
    output logic [7:0]            frame_length
);
    import crfp_pkg::*;

    logic       byte_valid_reg;
    logic [7:0] byte_reg;
    logic       out_valid_reg;
    result_t    res_reg;

    logic    res_valid;
    result_t res;
    logic    out_free;
    logic    byte_move;

    crfp_parser #(
        .MAX_FRAME(MAX_FRAME)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_valid(byte_move),
        .rx_byte   (byte_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    // bytes that close no frame pass even while a result waits
    assign out_free  = !out_valid_reg || !out_stall;
    assign byte_move = byte_valid_reg && (out_free || !res_valid);
    assign in_stall  = byte_valid_reg && !byte_move;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (!in_stall)
                byte_valid_reg <= in_valid;
            if (byte_move && res_valid)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
            byte_reg <= rx_byte;
        if (byte_move && res_valid)
            res_reg <= res;
    end

    assign out_valid    = out_valid_reg;
    assign result_code  = res_reg.code;
    assign command_code = res_reg.command;
    assign reply_status = res_reg.status;
    assign card_type    = res_reg.card_type;
    assign card_number  = res_reg.card_number;
    assign checksum_ok  = res_reg.sum_ok;
    assign frame_length = res_reg.length;

endmodule

@@ design/crfp_parser.sv @@
// ----------------------------------------------------------------------------
// crfp_parser
// Per-byte frame state: position, length, running xor and captured fields.
// Produces a result combinationally on the byte that ends a frame or on a bad length.
// ----------------------------------------------------------------------------
module crfp_parser #(
    parameter int MAX_FRAME = crfp_pkg::MAX_FRAME_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              byte_valid,
    input  logic [7:0]        rx_byte,
    output logic              res_valid,
    output crfp_pkg::result_t res
);
    import crfp_pkg::*;

    localparam logic [7:0] MaxLen = 8'(MAX_FRAME);

    logic [7:0]  pos_reg,    pos_next;
    logic [7:0]  len_reg,    len_next;
    logic [7:0]  xor_reg,    xor_next;
    logic [7:0]  cmd_reg,    cmd_next;
    logic [7:0]  status_reg, status_next;
    logic [15:0] type_reg,   type_next;
    logic [31:0] num_reg,    num_next;

    logic [7:0]   cmd_eff;
    logic [7:0]   status_eff;
    logic         last_byte;
    result_code_t code;

    always_comb
    begin
        // fields are captured even when they land on the checksum byte
        cmd_eff    = (pos_reg == POS_COMMAND) ? rx_byte : cmd_reg;
        status_eff = (pos_reg == POS_STATUS) ? rx_byte : status_reg;
        if (len_reg < LEN_WITH_STATUS)
        begin
            status_eff = 8'h00;
        end
        last_byte = ({1'b0, pos_reg} + 9'd1) == {1'b0, len_reg};

        case (cmd_eff)
            CMD_READ_CARD:
            begin
                if (len_reg < LEN_WITH_STATUS)
                    code = RES_CARD_SHORT;
                else if (status_eff != STATUS_OK)
                    code = RES_CARD_FAIL;
                else if (len_reg < LEN_WITH_CARD)
                    code = RES_CARD_SHORT;
                else
                    code = RES_CARD_OK;
            end
            CMD_READ_BLOCK:  code = RES_READ_BLOCK;
            CMD_WRITE_BLOCK: code = RES_WRITE_BLOCK;
            default:         code = RES_OTHER;
        endcase

        pos_next    = pos_reg;
        len_next    = len_reg;
        xor_next    = xor_reg;
        cmd_next    = cmd_reg;
        status_next = status_reg;
        type_next   = type_reg;
        num_next    = num_reg;
        res_valid   = 1'b0;
        res         = '0;
        res.code    = RES_BAD_LENGTH;

        if (pos_reg == 8'd0)
        begin
            pos_next    = POS_LENGTH;
            len_next    = 8'd0;
            xor_next    = rx_byte;
            cmd_next    = 8'h00;
            status_next = 8'h00;
            type_next   = 16'h0000;
            num_next    = 32'h0000_0000;
        end
        else if (pos_reg == POS_LENGTH)
        begin
            if (rx_byte < MIN_FRAME || rx_byte > MaxLen)
            begin
                res_valid  = 1'b1;
                res.code   = RES_BAD_LENGTH;
                res.length = rx_byte;
                pos_next   = 8'd0;
                len_next   = 8'd0;
                xor_next   = 8'h00;
            end
            else
            begin
                len_next = rx_byte;
                xor_next = xor_reg ^ rx_byte;
                pos_next = POS_COMMAND;
            end
        end
        else
        begin
            cmd_next    = cmd_eff;
            status_next = (pos_reg == POS_STATUS) ? rx_byte : status_reg;
            if (pos_reg >= POS_TYPE_FIRST && pos_reg <= POS_TYPE_LAST)
                type_next = {type_reg[7:0], rx_byte};
            if (pos_reg >= POS_NUM_FIRST && pos_reg <= POS_NUM_LAST)
                num_next = {num_reg[23:0], rx_byte};

            if (last_byte)
            begin
                res_valid       = 1'b1;
                res.code        = code;
                res.command     = cmd_eff;
                res.status      = status_eff;
                res.card_type   = (code == RES_CARD_OK) ? type_reg : 16'h0000;
                res.card_number = (code == RES_CARD_OK) ? num_reg : 32'h0000_0000;
                res.sum_ok      = (~xor_reg) == rx_byte;
                res.length      = len_reg;
                pos_next        = 8'd0;
                len_next        = 8'd0;
                xor_next        = 8'h00;
            end
            else
            begin
                xor_next = xor_reg ^ rx_byte;
                pos_next = pos_reg + 8'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= 8'd0;
            len_reg    <= 8'd0;
            xor_reg    <= 8'h00;
            cmd_reg    <= 8'h00;
            status_reg <= 8'h00;
            type_reg   <= 16'h0000;
            num_reg    <= 32'h0000_0000;
        end
        else if (byte_valid)
        begin
            pos_reg    <= pos_next;
            len_reg    <= len_next;
            xor_reg    <= xor_next;
            cmd_reg    <= cmd_next;
            status_reg <= status_next;
            type_reg   <= type_next;
            num_reg    <= num_next;
        end
    end

endmodule

@@ dv/card_reader_frame_parser_top_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// card_reader_frame_parser_top_tb
// Feeds reply frames byte by byte: a short table of hand-written frames, then
// mostly well-formed random frames mixed with bad lengths and stray bytes.
// Each frame result is checked against a byte-level bench parse or its table row.
// ----------------------------------------------------------------------------
module card_reader_frame_parser_top_tb;
    import crfp_pkg::*;

    localparam int DIRECTED_COUNT = 28;
    localparam int RANDOM_BYTES   = 1300;
    localparam int CALM_BYTES     = 150;
    localparam int WATCHDOG_LIMIT = 400;

    typedef struct packed {
        logic [7:0] data;
        bit         fixed;
        result_t    want;
    } frame_row_t;

    // bad lengths at both ends, short read block and write block frames, a card read
    // with a failing status and a full card read with a good checksum
    localparam frame_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
        '{8'hFF, 1'b0, '0},
        '{8'h00, 1'b1, '{RES_BAD_LENGTH, 8'h00, 8'h00, 16'h0000, 32'h0, 1'b0, 8'h00}},
        '{8'h00, 1'b0, '0},
        '{8'hFF, 1'b1, '{RES_BAD_LENGTH, 8'h00, 8'h00, 16'h0000, 32'h0, 1'b0, 8'hFF}},
        '{8'h7E, 1'b0, '0},
        '{8'h03, 1'b0, '0},
        '{8'hA3, 1'b0, '0},
        '{8'h01, 1'b0, '0},
        '{8'h04, 1'b0, '0},
        '{8'hA4, 1'b0, '0},
        '{8'h5E, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'h05, 1'b0, '0},
        '{8'hA1, 1'b0, '0},
        '{8'h6C, 1'b0, '0},
        '{8'h80, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'h0C, 1'b0, '0},
        '{8'hA1, 1'b0, '0},
        '{8'h55, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'h12, 1'b0, '0},
        '{8'h34, 1'b0, '0},
        '{8'hDE, 1'b0, '0},
        '{8'hAD, 1'b0, '0},
        '{8'hBE, 1'b0, '0},
        '{8'hEF, 1'b0, '0},
        '{8'h03, 1'b1, '{RES_CARD_OK, CMD_READ_CARD, STATUS_OK, 16'h1234, 32'hDEADBEEF,
                         1'b1, 8'd12}}
    };

    logic         clk;
    logic         rst_n;
    logic         in_valid;
    logic         in_stall;
    logic [7:0]   rx_byte;
    logic         out_valid;
    logic         out_stall;
    result_code_t result_code;
    logic [7:0]   command_code;
    logic [7:0]   reply_status;
    logic [15:0]  card_type;
    logic [31:0]  card_number;
    logic         checksum_ok;
    logic [7:0]   frame_length;

    // parse state tracked alongside the block
    logic [7:0]  frame_pos    = '0;
    logic [7:0]  frame_len    = '0;
    logic [7:0]  frame_xor    = '0;
    logic [7:0]  frame_cmd    = '0;
    logic [7:0]  frame_status = '0;
    logic [15:0] frame_type   = '0;
    logic [31:0] frame_number = '0;

    result_t     due_frames[$];
    int          mismatches = 0;
    int          frames_seen = 0;
    int unsigned gap_pct = 20;
    int unsigned stall_pct = 20;
    int unsigned stall_left = 0;
    int unsigned pace_choices[4] = '{0, 5, 20, 50};

    card_reader_frame_parser_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .result_code  (result_code),
        .command_code (command_code),
        .reply_status (reply_status),
        .card_type    (card_type),
        .card_number  (card_number),
        .checksum_ok  (checksum_ok),
        .frame_length (frame_length)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic void clear_frame_state();
        frame_pos    = '0;
        frame_len    = '0;
        frame_xor    = '0;
        frame_cmd    = '0;
        frame_status = '0;
        frame_type   = '0;
        frame_number = '0;
    endfunction

    // advances the tracked parse by one byte; returns 1 when a frame result is due
    function automatic bit parse_rx_byte(input logic [7:0] b, output result_t res);
        logic [7:0] status;
        res = '0;
        if (frame_pos == 8'd0)
        begin
            clear_frame_state();
            frame_xor = b;
            frame_pos = POS_LENGTH;
            return 1'b0;
        end
        if (frame_pos == POS_LENGTH)
        begin
            if (b < MIN_FRAME || int'(b) > MAX_FRAME_DEF)
            begin
                res.code   = RES_BAD_LENGTH;
                res.length = b;
                clear_frame_state();
                return 1'b1;
            end
            frame_len = b;
            frame_xor = frame_xor ^ b;
            frame_pos = POS_COMMAND;
            return 1'b0;
        end

        // fields are captured even when they land on the checksum byte
        if (frame_pos == POS_COMMAND)
            frame_cmd = b;
        else if (frame_pos == POS_STATUS)
            frame_status = b;
        else if (frame_pos >= POS_TYPE_FIRST && frame_pos <= POS_TYPE_LAST)
            frame_type = {frame_type[7:0], b};
        else if (frame_pos >= POS_NUM_FIRST && frame_pos <= POS_NUM_LAST)
            frame_number = {frame_number[23:0], b};

        if ({1'b0, frame_pos} + 9'd1 != {1'b0, frame_len})
        begin
            frame_xor = frame_xor ^ b;
            frame_pos = frame_pos + 8'd1;
            return 1'b0;
        end

        status = (frame_len >= LEN_WITH_STATUS) ? frame_status : 8'h00;
        if (frame_cmd == CMD_READ_CARD)
        begin
            if (frame_len < LEN_WITH_STATUS)
                res.code = RES_CARD_SHORT;
            else if (status != STATUS_OK)
                res.code = RES_CARD_FAIL;
            else if (frame_len < LEN_WITH_CARD)
                res.code = RES_CARD_SHORT;
            else
                res.code = RES_CARD_OK;
        end
        else if (frame_cmd == CMD_READ_BLOCK)
            res.code = RES_READ_BLOCK;
        else if (frame_cmd == CMD_WRITE_BLOCK)
            res.code = RES_WRITE_BLOCK;
        else
            res.code = RES_OTHER;

        res.command     = frame_cmd;
        res.status      = status;
        res.card_type   = (res.code == RES_CARD_OK) ? frame_type : 16'h0000;
        res.card_number = (res.code == RES_CARD_OK) ? frame_number : 32'h0;
        res.sum_ok      = ((frame_xor ^ b) == 8'hFF);
        res.length      = frame_len;
        clear_frame_state();
        return 1'b1;
    endfunction

    task automatic send_byte(input logic [7:0] b, input bit fixed, input result_t want);
        result_t due;
        if (gap_pct != 0 && $urandom_range(99) < gap_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(13, 1)) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        if (parse_rx_byte(b, due))
            due_frames.push_back(fixed ? want : due);
    endtask

    // receiver stalls in bursts
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_left != 0)
            begin
                stall_left = stall_left - 1;
                if (stall_left == 0)
                    out_stall <= 1'b0;
            end
            else if (stall_pct != 0 && $urandom_range(99) < stall_pct)
            begin
                stall_left = $urandom_range(13, 1);
                out_stall <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        result_t got;
        result_t want;
        if (out_valid && !out_stall)
        begin
            got = '{result_code, command_code, reply_status, card_type, card_number,
                    checksum_ok, frame_length};
            if (due_frames.size() == 0)
            begin
                if (mismatches < 10)
                    $display("%t: result %0d with none due: code %0d cmd %h len %0d",
                             $realtime, frames_seen, got.code, got.command, got.length);
                mismatches++;
            end
            else
            begin
                want = due_frames.pop_front();
                if (got.code !== want.code || got.command !== want.command ||
                    got.status !== want.status || got.card_type !== want.card_type ||
                    got.card_number !== want.card_number || got.sum_ok !== want.sum_ok ||
                    got.length !== want.length)
                begin
                    if (mismatches < 10)
                    begin
                        $display("%t: result %0d mismatch", $realtime, frames_seen);
                        $display("  exp code %0d cmd %h sts %h type %h num %h sum %b len %0d",
                                 want.code, want.command, want.status, want.card_type,
                                 want.card_number, want.sum_ok, want.length);
                        $display("  got code %0d cmd %h sts %h type %h num %h sum %b len %0d",
                                 got.code, got.command, got.status, got.card_type,
                                 got.card_number, got.sum_ok, got.length);
                    end
                    mismatches++;
                end
            end
            frames_seen++;
        end
    end

    // ends the run when no transaction moves on either side for too long
    initial
    begin : watchdog
        int idle;
        idle = 0;
        @(posedge rst_n);
        while (idle < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle = 0;
            else
                idle++;
        end
        $display("[card_reader_frame_parser_top] ERROR");
        $finish;
    end

    initial
    begin : stimulus
        logic [7:0] tx_bytes[$];
        logic [7:0] len;
        logic [7:0] cmd;
        logic [7:0] sum_acc;
        int         sent;
        int         next_segment;
        int         segment;
        int         kind;
        int         pick;

        rst_n    = 1'b0;
        in_valid = 1'b0;
        rx_byte  = 8'h00;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIRECTED_COUNT; i++)
            send_byte(DIRECTED_ROWS[i].data, DIRECTED_ROWS[i].fixed, DIRECTED_ROWS[i].want);

        sent         = 0;
        next_segment = 100;
        segment      = 0;
        while (sent < RANDOM_BYTES)
        begin
            if (RANDOM_BYTES - sent <= CALM_BYTES)
            begin
                gap_pct   = 0;
                stall_pct = 0;
            end
            else if (sent >= next_segment)
            begin
                next_segment += 100;
                segment++;
                // hold the sender until every due result is out
                if (segment % 4 == 1)
                begin
                    in_valid <= 1'b0;
                    @(posedge clk);
                    wait (due_frames.size() == 0);
                end
                gap_pct   = pace_choices[$urandom_range(3)];
                stall_pct = pace_choices[$urandom_range(3)];
            end

            tx_bytes.delete();
            kind = $urandom_range(99);
            if (kind < 8)
            begin
                tx_bytes.push_back(8'($urandom_range(255)));
                if ($urandom_range(1) != 0)
                    tx_bytes.push_back(8'($urandom_range(MIN_FRAME - 1)));
                else
                    tx_bytes.push_back(8'($urandom_range(255, MAX_FRAME_DEF + 1)));
            end
            else if (kind < 15)
            begin
                // stray bytes that knock the parse out of step
                repeat ($urandom_range(4, 1)) tx_bytes.push_back(8'($urandom_range(255)));
            end
            else
            begin
                pick = $urandom_range(99);
                if (pick < 35)
                    len = 8'($urandom_range(16, LEN_WITH_CARD));
                else if (pick < 60)
                    len = 8'($urandom_range(LEN_WITH_CARD - 1, MIN_FRAME));
                else if (pick < 70)
                    len = 8'(MAX_FRAME_DEF);
                else
                    len = 8'($urandom_range(MAX_FRAME_DEF, MIN_FRAME));
                pick = $urandom_range(99);
                if (pick < 45)
                    cmd = CMD_READ_CARD;
                else if (pick < 60)
                    cmd = CMD_READ_BLOCK;
                else if (pick < 75)
                    cmd = CMD_WRITE_BLOCK;
                else
                    cmd = 8'($urandom_range(255));
                tx_bytes.push_back(8'($urandom_range(255)));
                tx_bytes.push_back(len);
                sum_acc = tx_bytes[0] ^ len;
                for (int i = 2; i < int'(len) - 1; i++)
                begin
                    if (i == 2)
                        tx_bytes.push_back(cmd);
                    else if (i == 4 && cmd == CMD_READ_CARD && $urandom_range(3) != 0)
                        tx_bytes.push_back(STATUS_OK);
                    else
                        tx_bytes.push_back(8'($urandom_range(255)));
                    sum_acc = sum_acc ^ tx_bytes[i];
                end
                if ($urandom_range(9) != 0)
                    tx_bytes.push_back(~sum_acc);
                else
                    tx_bytes.push_back(8'($urandom_range(255)));
            end

            foreach (tx_bytes[i])
                send_byte(tx_bytes[i], 1'b0, '0);
            sent += tx_bytes.size();
        end

        in_valid <= 1'b0;
        wait (due_frames.size() == 0);
        repeat (8) @(posedge clk);
        if (mismatches == 0 && due_frames.size() == 0)
            $display("[card_reader_frame_parser_top] OK");
        else
            $display("[card_reader_frame_parser_top] ERROR");
        $finish;
    end

endmodule
